// ----- design/i2c_master_bit_sequencer_core_assert.svh -----
// assertion macros shared by the checker of the i2c bit sequencer
`ifndef I2C_MASTER_BIT_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define I2CBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define I2CBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/i2cbs_pkg.sv -----
// types, constants and phase tables of the i2c bit sequencer
package i2cbs_pkg;

  localparam int unsigned TickW  = 16;
  localparam int unsigned PhaseW = 6;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned InW    = 16;
  localparam int unsigned OutW   = 16;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_SEND  = 3'd3,
    CMD_WAIT  = 3'd4,
    CMD_READ  = 3'd5,
    CMD_ACK   = 3'd6,
    CMD_NACK  = 3'd7
  } cmd_t;

  typedef struct packed {
    logic scl;
    logic sda;
  } drive_t;

  // number of phases in each command
  function automatic logic [PhaseW-1:0] phase_count(input cmd_t cmd);
    logic [PhaseW-1:0] n;
    case (cmd)
      CMD_START: n = PhaseW'(4);
      CMD_STOP:  n = PhaseW'(4);
      CMD_SEND:  n = PhaseW'(33);
      CMD_WAIT:  n = PhaseW'(5);
      CMD_READ:  n = PhaseW'(24);
      CMD_ACK:   n = PhaseW'(5);
      CMD_NACK:  n = PhaseW'(3);
      default:   n = PhaseW'(0);
    endcase
    return n;
  endfunction

  // remainder by three: four is one modulo three, so the base-four digits add up
  function automatic logic [1:0] mod3(input logic [PhaseW-1:0] p);
    logic [3:0] s;
    s = {2'b00, p[1:0]} + {2'b00, p[3:2]} + {2'b00, p[5:4]};
    if (s >= 4'd6) begin
      s = s - 4'd6;
    end
    if (s >= 4'd3) begin
      s = s - 4'd3;
    end
    return s[1:0];
  endfunction

  // sda is released to the slave for these phases
  function automatic logic sda_is_input(input cmd_t cmd, input logic [PhaseW-1:0] p);
    logic r;
    case (cmd)
      CMD_READ: r = 1'b1;
      CMD_WAIT: r = (p >= PhaseW'(1)) && (p <= PhaseW'(3));
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

  // drive levels after entering phase p of a command
  function automatic drive_t enter_phase(input cmd_t cmd, input logic [PhaseW-1:0] p,
                                         input logic [ByteW-1:0] sb, input drive_t cur);
    drive_t d;
    d = cur;
    case (cmd)
      CMD_START: begin
        if (p == PhaseW'(0)) d.sda = 1'b1;
        else if (p == PhaseW'(1)) d.scl = 1'b1;
        else if (p == PhaseW'(2)) d.sda = 1'b0;
        else d.scl = 1'b0;
      end
      CMD_STOP: begin
        if (p == PhaseW'(0)) d.scl = 1'b0;
        else if (p == PhaseW'(1)) d.sda = 1'b0;
        else if (p == PhaseW'(2)) d.scl = 1'b1;
        else d.sda = 1'b1;
      end
      CMD_SEND: begin
        if (p >= PhaseW'(32)) begin
          d.sda = 1'b1;
        end else if (p[1:0] == 2'd0 || p[1:0] == 2'd3) begin
          d.scl = 1'b0;
        end else if (p[1:0] == 2'd1) begin
          // msb first: bit index is seven minus the bit number
          d.sda = sb[~p[4:2]];
        end else begin
          d.scl = 1'b1;
        end
      end
      CMD_WAIT: begin
        if (p == PhaseW'(0) || p == PhaseW'(3)) d.scl = 1'b0;
        else if (p == PhaseW'(2)) d.scl = 1'b1;
        else if (p == PhaseW'(4)) d.sda = 1'b1;
      end
      CMD_READ: begin
        d.scl = (mod3(p) == 2'd1);
      end
      CMD_ACK: begin
        if (p == PhaseW'(0)) begin
          d.scl = 1'b0;
          d.sda = 1'b1;
        end else if (p == PhaseW'(1)) d.sda = 1'b0;
        else if (p == PhaseW'(2)) d.scl = 1'b1;
        else if (p == PhaseW'(3)) d.scl = 1'b0;
        else d.sda = 1'b1;
      end
      CMD_NACK: begin
        if (p == PhaseW'(0)) begin
          d.scl = 1'b0;
          d.sda = 1'b1;
        end else if (p == PhaseW'(1)) d.scl = 1'b1;
        else d.scl = 1'b0;
      end
      default: begin
        d = cur;
      end
    endcase
    return d;
  endfunction

endpackage

// ----- design/i2c_master_bit_sequencer_core.sv -----
// top level of the open-drain i2c master bit sequencer
//
// Each input beat is one bus tick: it carries a command code (taken only
// while idle), the byte for a send and the sampled sda level. Every accepted
// beat yields exactly one output beat with the scl and sda drive for that tick
// (1 means released), busy, a one-tick done pulse, the last read byte and the
// acknowledge flag. A command walks a fixed list of bus phases; each phase
// lasts cfg_data ticks (zero counts as one). Rate: one tick is accepted in
// every clock cycle unless the output stalls, and its output beat appears in
// the output register on the next cycle. The tick logic sits between the input
// handshake and that output register; the input side stalls only while a
// finished output beat waits for m_tready. The user must write phase_ticks via
// cfg_we/cfg_data only while the sequencer is idle (unchecked); resets to five.
module i2c_master_bit_sequencer_core (
  input  logic                         clk,
  input  logic                         rst,
  // s_tdata: req_type[2:0], wr_data[10:3], sda_in[11], zero fill above
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [i2cbs_pkg::InW-1:0]    s_tdata,
  // m_tdata: scl_level[0], sda_level[1], busy_res[2], done_res[3],
  //          read_data[11:4], ack_received[12], zero fill above
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [i2cbs_pkg::OutW-1:0]   m_tdata,
  // phase_ticks register write
  input  logic                         cfg_we,
  input  logic [i2cbs_pkg::TickW-1:0]  cfg_data
);

  // sequencer state
  i2cbs_pkg::cmd_t                      cmd, cmd_next;
  logic [i2cbs_pkg::PhaseW-1:0]         phase, phase_next;
  logic [i2cbs_pkg::TickW-1:0]          tick_cnt, tick_cnt_next;
  logic [i2cbs_pkg::ByteW-1:0]          shift_byte, shift_byte_next;
  i2cbs_pkg::drive_t                    drive, drive_next;
  logic                                 ack_flag, ack_flag_next;
  logic [i2cbs_pkg::ByteW-1:0]          read_hold, read_hold_next;
  logic [i2cbs_pkg::TickW-1:0]          phase_ticks;

  // input beat fields
  logic [2:0]                           req_type;
  logic [i2cbs_pkg::ByteW-1:0]          wr_data;
  logic                                 sda_in;
  logic                                 accept;

  // values of this tick after a possible command start
  i2cbs_pkg::cmd_t                      cmd_cur;
  logic [i2cbs_pkg::PhaseW-1:0]         phase_cur;
  logic [i2cbs_pkg::TickW-1:0]          tick_cur;
  logic [i2cbs_pkg::ByteW-1:0]          sb_cur;
  i2cbs_pkg::drive_t                    drive_cur;
  logic [i2cbs_pkg::TickW-1:0]          limit;
  logic [i2cbs_pkg::TickW:0]            tick_inc;
  logic [i2cbs_pkg::PhaseW-1:0]         phase_inc;
  logic                                 done;

  // result fields for the output register
  logic                                 scl_level, sda_level;
  logic [i2cbs_pkg::OutW-1:0]           out_word;

  assign req_type = s_tdata[2:0];
  assign wr_data  = s_tdata[10:3];
  assign sda_in   = s_tdata[11];

  // output register frees up when it is empty or being drained
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // next state of the sequencer for one tick
  always_comb begin
    cmd_next        = cmd;
    phase_next      = phase;
    tick_cnt_next   = tick_cnt;
    shift_byte_next = shift_byte;
    drive_next      = drive;
    ack_flag_next   = ack_flag;
    read_hold_next  = read_hold;
    done            = 1'b0;

    // a command is taken only while idle; it enters phase 0 at once
    if (cmd == i2cbs_pkg::CMD_IDLE && req_type != 3'(i2cbs_pkg::CMD_IDLE)) begin
      cmd_cur   = i2cbs_pkg::cmd_t'(req_type);
      phase_cur = '0;
      tick_cur  = '0;
      sb_cur    = (i2cbs_pkg::cmd_t'(req_type) == i2cbs_pkg::CMD_SEND) ? wr_data : '0;
      drive_cur = i2cbs_pkg::enter_phase(i2cbs_pkg::cmd_t'(req_type), '0, sb_cur, drive);
    end else begin
      cmd_cur   = cmd;
      phase_cur = phase;
      tick_cur  = tick_cnt;
      sb_cur    = shift_byte;
      drive_cur = drive;
    end

    limit     = (phase_ticks == '0) ? i2cbs_pkg::TickW'(1) : phase_ticks;
    tick_inc  = {1'b0, tick_cur} + (i2cbs_pkg::TickW + 1)'(1);
    phase_inc = phase_cur + i2cbs_pkg::PhaseW'(1);

    if (accept) begin
      cmd_next        = cmd_cur;
      phase_next      = phase_cur;
      tick_cnt_next   = tick_cur;
      shift_byte_next = sb_cur;
      drive_next      = drive_cur;
      if (cmd_cur != i2cbs_pkg::CMD_IDLE) begin
        if (tick_inc >= {1'b0, limit}) begin
          // last tick of the phase: sample at the end of scl high
          if (cmd_cur == i2cbs_pkg::CMD_READ && i2cbs_pkg::mod3(phase_cur) == 2'd1) begin
            shift_byte_next = {sb_cur[i2cbs_pkg::ByteW-2:0], sda_in};
          end else if (cmd_cur == i2cbs_pkg::CMD_WAIT &&
                       phase_cur == i2cbs_pkg::PhaseW'(2)) begin
            ack_flag_next = !sda_in;
          end
          tick_cnt_next = '0;
          if (phase_inc >= i2cbs_pkg::phase_count(cmd_cur)) begin
            if (cmd_cur == i2cbs_pkg::CMD_READ) begin
              read_hold_next = shift_byte_next;
            end
            cmd_next   = i2cbs_pkg::CMD_IDLE;
            phase_next = '0;
            done       = 1'b1;
          end else begin
            phase_next = phase_inc;
            drive_next = i2cbs_pkg::enter_phase(cmd_cur, phase_inc, shift_byte_next,
                                                drive_cur);
          end
        end else begin
          tick_cnt_next = tick_inc[i2cbs_pkg::TickW-1:0];
        end
      end
    end
  end

  // result beat of this tick: the drives of the current phase
  always_comb begin
    scl_level = drive_cur.scl;
    sda_level = i2cbs_pkg::sda_is_input(cmd_cur, phase_cur) ? 1'b1 : drive_cur.sda;
    out_word  = '0;
    out_word[0]    = scl_level;
    out_word[1]    = sda_level;
    out_word[2]    = (cmd_next != i2cbs_pkg::CMD_IDLE);
    out_word[3]    = done;
    out_word[11:4] = read_hold_next;
    out_word[12]   = ack_flag_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd         <= i2cbs_pkg::CMD_IDLE;
      phase       <= '0;
      tick_cnt    <= '0;
      shift_byte  <= '0;
      drive       <= '{scl: 1'b1, sda: 1'b1};
      ack_flag    <= 1'b0;
      read_hold   <= '0;
      phase_ticks <= i2cbs_pkg::TickW'(5);
    end else begin
      cmd        <= cmd_next;
      phase      <= phase_next;
      tick_cnt   <= tick_cnt_next;
      shift_byte <= shift_byte_next;
      drive      <= drive_next;
      ack_flag   <= ack_flag_next;
      read_hold  <= read_hold_next;
      if (cfg_we) begin
        phase_ticks <= cfg_data;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= out_word;
    end
  end

endmodule

// ----- design/i2cbs_checker.sv -----
// port-level checks of the i2c bit sequencer, bound to the top level
`include "i2c_master_bit_sequencer_core_assert.svh"

module i2cbs_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [i2cbs_pkg::OutW-1:0]   m_tdata
);

  // a stalled result beat stays put
  `I2CBS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata), "stalled output beat changed")

  // every accepted tick produces a result beat
  `I2CBS_ASSERT_NEXT(a_one_result, clk, rst, s_tvalid && s_tready, m_tvalid,
    "accepted tick gave no result")

  // an empty output register never blocks the input
  `I2CBS_ASSERT_NOW(a_ready_empty, clk, rst, !m_tvalid, s_tready,
    "input blocked with empty output")

  // the done tick ends the command, so busy is low with it
  `I2CBS_ASSERT_NOW(a_done_idle, clk, rst, m_tvalid && m_tdata[3], !m_tdata[2],
    "done with busy set")

endmodule

bind i2c_master_bit_sequencer_core i2cbs_checker u_i2cbs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- sim/tb_i2c_master_bit_sequencer_core.sv -----
// self-checking testbench for the i2c master bit sequencer core
module tb_i2c_master_bit_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  // output beat fields, packed to line up with m_tdata[12:0]
  typedef struct packed {
    logic       ack;
    logic [7:0] rd;
    logic       done;
    logic       busy;
    logic       sda;
    logic       scl;
  } bus_beat_t;

  // one row of the directed plan
  typedef struct packed {
    logic              load;     // write the phase length before the command
    logic [15:0]       len;
    i2cbs_pkg::cmd_t   cmd;
    logic [7:0]        wr;
    logic [7:0]        bits;     // sda seen by a read, bit 0 answers a wait ack
    logic              noise;    // stray requests while busy
    logic              pin_rd;
    logic [7:0]        rd;
    logic              pin_ack;
    logic              ack;
  } plan_row_t;

  localparam int NROWS = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [5:0] PHASE_COUNT [8] = '{6'd0, 6'd4, 6'd4, 6'd33, 6'd5, 6'd24, 6'd5, 6'd3};

  // read results and acknowledge levels here are obvious from the sda pattern
  localparam plan_row_t PLAN [NROWS] = '{
    '{1'b0, 16'd0, i2cbs_pkg::CMD_IDLE,  8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{1'b0, 16'd0, i2cbs_pkg::CMD_START, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{1'b1, 16'd0, i2cbs_pkg::CMD_SEND,  8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{1'b0, 16'd0, i2cbs_pkg::CMD_SEND,  8'hff, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{1'b0, 16'd0, i2cbs_pkg::CMD_WAIT,  8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1},
    '{1'b0, 16'd0, i2cbs_pkg::CMD_WAIT,  8'h00, 8'hff, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0},
    '{1'b0, 16'd0, i2cbs_pkg::CMD_READ,  8'h00, 8'ha5, 1'b0, 1'b1, 8'ha5, 1'b0, 1'b0},
    '{1'b0, 16'd0, i2cbs_pkg::CMD_READ,  8'hff, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
    '{1'b0, 16'd0, i2cbs_pkg::CMD_READ,  8'h00, 8'hff, 1'b0, 1'b1, 8'hff, 1'b0, 1'b0},
    '{1'b0, 16'd0, i2cbs_pkg::CMD_ACK,   8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{1'b0, 16'd0, i2cbs_pkg::CMD_NACK,  8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{1'b0, 16'd0, i2cbs_pkg::CMD_STOP,  8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{1'b1, 16'd1, i2cbs_pkg::CMD_START, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{1'b0, 16'd0, i2cbs_pkg::CMD_SEND,  8'h5a, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{1'b0, 16'd0, i2cbs_pkg::CMD_WAIT,  8'h00, 8'h01, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0},
    '{1'b0, 16'd0, i2cbs_pkg::CMD_READ,  8'h00, 8'h3c, 1'b1, 1'b1, 8'h3c, 1'b0, 1'b0},
    '{1'b0, 16'd0, i2cbs_pkg::CMD_STOP,  8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{1'b1, 16'd2, i2cbs_pkg::CMD_NACK,  8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{1'b0, 16'd0, i2cbs_pkg::CMD_ACK,   8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
    '{1'b1, 16'd3, i2cbs_pkg::CMD_NACK,  8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{1'b1, 16'd2, i2cbs_pkg::CMD_READ,  8'h00, 8'hc3, 1'b1, 1'b1, 8'hc3, 1'b0, 1'b0},
    '{1'b0, 16'd0, i2cbs_pkg::CMD_WAIT,  8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1},
    '{1'b1, 16'd0, i2cbs_pkg::CMD_SEND,  8'h81, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
    '{1'b0, 16'd0, i2cbs_pkg::CMD_STOP,  8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}
  };

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [i2cbs_pkg::InW-1:0]     s_tdata;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [i2cbs_pkg::OutW-1:0]    m_tdata;
  logic                          cfg_we;
  logic [i2cbs_pkg::TickW-1:0]   cfg_data;

  // predicted sequencer state
  i2cbs_pkg::cmd_t bus_cmd;
  logic [5:0]      bus_phase;
  logic [15:0]     hold_cnt;
  logic [7:0]      shift_reg;
  logic            scl_drv;
  logic            sda_drv;
  logic            ack_seen;
  logic [7:0]      last_read;
  logic [15:0]     phase_len;

  bus_beat_t   expected_beats [$];

  // typed-in values that override the prediction on a done beat
  logic        pin_rd_on;
  logic [7:0]  pin_rd_val;
  logic        pin_ack_on;
  logic        pin_ack_val;

  int unsigned errors;
  int unsigned cmd_count;
  int unsigned tick_count;
  int unsigned quiet_cycles;
  int unsigned tx_gap_pct;
  int unsigned rx_stall_pct;

  i2c_master_bit_sequencer_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // drive change applied when the predicted sequencer enters a phase
  function automatic void load_phase_drive();
    logic [5:0] p;
    p = bus_phase;
    case (bus_cmd)
      i2cbs_pkg::CMD_START: begin
        case (p)
          6'd0: sda_drv = 1'b1;
          6'd1: scl_drv = 1'b1;
          6'd2: sda_drv = 1'b0;
          default: scl_drv = 1'b0;
        endcase
      end
      i2cbs_pkg::CMD_STOP: begin
        case (p)
          6'd0: scl_drv = 1'b0;
          6'd1: sda_drv = 1'b0;
          6'd2: scl_drv = 1'b1;
          default: sda_drv = 1'b1;
        endcase
      end
      i2cbs_pkg::CMD_SEND: begin
        // four phases per bit, msb first, then release sda
        if (p >= 6'd32) sda_drv = 1'b1;
        else if (p[1:0] == 2'd1) sda_drv = shift_reg[3'd7 - p[4:2]];
        else if (p[1:0] == 2'd2) scl_drv = 1'b1;
        else scl_drv = 1'b0;
      end
      i2cbs_pkg::CMD_WAIT: begin
        if (p == 6'd0 || p == 6'd3) scl_drv = 1'b0;
        else if (p == 6'd2) scl_drv = 1'b1;
        else if (p == 6'd4) sda_drv = 1'b1;
      end
      i2cbs_pkg::CMD_READ: scl_drv = (p % 3 == 1);
      i2cbs_pkg::CMD_ACK: begin
        case (p)
          6'd0: begin
            scl_drv = 1'b0;
            sda_drv = 1'b1;
          end
          6'd1: sda_drv = 1'b0;
          6'd2: scl_drv = 1'b1;
          6'd3: scl_drv = 1'b0;
          default: sda_drv = 1'b1;
        endcase
      end
      i2cbs_pkg::CMD_NACK: begin
        case (p)
          6'd0: begin
            scl_drv = 1'b0;
            sda_drv = 1'b1;
          end
          6'd1: scl_drv = 1'b1;
          default: scl_drv = 1'b0;
        endcase
      end
      default: ;
    endcase
  endfunction

  // advance the predicted sequencer by one tick and return its output beat
  function automatic bus_beat_t i2c_tick(i2cbs_pkg::cmd_t req, logic [7:0] wr, logic sda_in);
    bus_beat_t b;
    int unsigned lim;
    if (bus_cmd == i2cbs_pkg::CMD_IDLE && req != i2cbs_pkg::CMD_IDLE) begin
      bus_cmd   = req;
      bus_phase = '0;
      hold_cnt  = '0;
      shift_reg = (req == i2cbs_pkg::CMD_SEND) ? wr : 8'h00;
      load_phase_drive();
    end
    b.scl = scl_drv;
    // sda released while the slave owns the line
    b.sda = (bus_cmd == i2cbs_pkg::CMD_READ ||
             (bus_cmd == i2cbs_pkg::CMD_WAIT && bus_phase >= 6'd1 && bus_phase <= 6'd3)) ?
            1'b1 : sda_drv;
    b.done = 1'b0;
    if (bus_cmd != i2cbs_pkg::CMD_IDLE) begin
      lim = (phase_len == 16'd0) ? 1 : phase_len;
      if (32'(hold_cnt) + 1 >= lim) begin
        // sample at the end of the scl high phase
        if (bus_cmd == i2cbs_pkg::CMD_READ && bus_phase % 3 == 1)
          shift_reg = {shift_reg[6:0], sda_in};
        else if (bus_cmd == i2cbs_pkg::CMD_WAIT && bus_phase == 6'd2)
          ack_seen = ~sda_in;
        hold_cnt  = '0;
        bus_phase = bus_phase + 6'd1;
        if (bus_phase >= PHASE_COUNT[bus_cmd]) begin
          if (bus_cmd == i2cbs_pkg::CMD_READ) last_read = shift_reg;
          bus_cmd   = i2cbs_pkg::CMD_IDLE;
          bus_phase = '0;
          b.done    = 1'b1;
        end else begin
          load_phase_drive();
        end
      end else begin
        hold_cnt = hold_cnt + 16'd1;
      end
    end
    b.busy = (bus_cmd != i2cbs_pkg::CMD_IDLE);
    b.rd   = last_read;
    b.ack  = ack_seen;
    return b;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 10) $display("mismatch %s: expected %0h got %0h at %0t", name, want, got, $time);
    end
  endtask

  // monitor: compare accepted output beats, then predict the accepted input beat
  always @(posedge clk) begin
    bus_beat_t want;
    bus_beat_t got;
    if (!rst) begin
      if (cfg_we) phase_len = cfg_data;
      if (m_tvalid && m_tready) begin
        got = bus_beat_t'(m_tdata[12:0]);
        if (expected_beats.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("mismatch unexpected output beat: expected none got %0h at %0t",
                     m_tdata, $time);
        end else begin
          want = expected_beats.pop_front();
          check_field("scl_level", want.scl, got.scl);
          check_field("sda_level", want.sda, got.sda);
          check_field("busy", want.busy, got.busy);
          check_field("done", want.done, got.done);
          check_field("read_data", want.rd, got.rd);
          check_field("ack_received", want.ack, got.ack);
          check_field("zero fill", 0, m_tdata[i2cbs_pkg::OutW-1:13]);
        end
      end
      if (s_tvalid && s_tready) begin
        want = i2c_tick(i2cbs_pkg::cmd_t'(s_tdata[2:0]), s_tdata[10:3], s_tdata[11]);
        if (want.done && pin_rd_on) want.rd = pin_rd_val;
        if (want.done && pin_ack_on) want.ack = pin_ack_val;
        expected_beats.push_back(want);
      end
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // one input beat through the handshake, returns at the following falling edge
  task automatic send_tick(input i2cbs_pkg::cmd_t req, input logic [7:0] wr, input logic sda);
    while ($urandom_range(99) < tx_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, sda, wr, req};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tick_count++;
    @(negedge clk);
  endtask

  // slave side of sda for the next tick, seen from the predicted phase
  function automatic logic slave_sda(input logic [7:0] bits);
    if (bus_cmd == i2cbs_pkg::CMD_READ) return bits[3'd7 - 3'(bus_phase / 3)];
    if (bus_cmd == i2cbs_pkg::CMD_WAIT) return bits[0];
    return 1'($urandom_range(1));
  endfunction

  // issue one command and keep ticking until the sequencer goes idle
  task automatic run_cmd(input i2cbs_pkg::cmd_t c, input logic [7:0] wr,
                         input logic [7:0] bits, input logic noise);
    if (c != i2cbs_pkg::CMD_IDLE) cmd_count++;
    send_tick(c, wr, slave_sda(bits));
    while (bus_cmd != i2cbs_pkg::CMD_IDLE) begin
      // requests arriving while busy must be dropped
      if (noise && $urandom_range(3) == 0)
        send_tick(i2cbs_pkg::cmd_t'($urandom_range(7)), 8'($urandom), slave_sda(bits));
      else
        send_tick(i2cbs_pkg::CMD_IDLE, 8'($urandom), slave_sda(bits));
    end
  endtask

  // hold the sender until every output beat is back, then write phase_ticks
  task automatic load_len(input logic [15:0] v);
    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // short phase lengths, from zero to three, keep each command brief
  function automatic logic [15:0] pick_len();
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd2;
      default: return 16'($urandom_range(3, 1));
    endcase
  endfunction

  // well-formed transfers with random content, mixed with stray commands
  task automatic random_traffic(input int unsigned n_ticks);
    int unsigned stop_at;
    int unsigned n_bytes;
    logic [7:0]  addr;
    stop_at = tick_count + n_ticks;
    while (tick_count < stop_at) begin
      if ($urandom_range(7) == 0) load_len(pick_len());
      if ($urandom_range(5) == 0) repeat ($urandom_range(3, 1))
        run_cmd(i2cbs_pkg::CMD_IDLE, 8'($urandom), 8'($urandom), 1'b0);
      if ($urandom_range(9) < 3) begin
        addr = 8'($urandom);
        n_bytes = $urandom_range(2, 1);
        run_cmd(i2cbs_pkg::CMD_START, 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
        run_cmd(i2cbs_pkg::CMD_SEND, addr, 8'($urandom), 1'($urandom_range(1)));
        // slave mostly acknowledges
        run_cmd(i2cbs_pkg::CMD_WAIT, 8'($urandom), {7'($urandom), ($urandom_range(4) == 0)},
                1'($urandom_range(1)));
        for (int i = 0; i < n_bytes; i++) begin
          if (addr[0]) begin
            run_cmd(i2cbs_pkg::CMD_READ, 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
            run_cmd((i == n_bytes - 1) ? i2cbs_pkg::CMD_NACK : i2cbs_pkg::CMD_ACK,
                    8'($urandom), 8'($urandom), 1'($urandom_range(1)));
          end else begin
            run_cmd(i2cbs_pkg::CMD_SEND, 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
            run_cmd(i2cbs_pkg::CMD_WAIT, 8'($urandom),
                    {7'($urandom), ($urandom_range(4) == 0)}, 1'($urandom_range(1)));
          end
        end
        run_cmd(i2cbs_pkg::CMD_STOP, 8'($urandom), 8'($urandom), 1'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(4, 1))
          run_cmd(i2cbs_pkg::cmd_t'($urandom_range(7)), 8'($urandom), 8'($urandom),
                  1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    m_tready     = 1'b0;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    pin_rd_on    = 1'b0;
    pin_rd_val   = '0;
    pin_ack_on   = 1'b0;
    pin_ack_val  = 1'b0;
    errors       = 0;
    cmd_count    = 0;
    tick_count   = 0;
    quiet_cycles = 0;
    tx_gap_pct   = 18;
    rx_stall_pct = 45;
    // predicted reset state
    bus_cmd      = i2cbs_pkg::CMD_IDLE;
    bus_phase    = '0;
    hold_cnt     = '0;
    shift_reg    = '0;
    scl_drv      = 1'b1;
    sda_drv      = 1'b1;
    ack_seen     = 1'b0;
    last_read    = '0;
    phase_len    = 16'd5;

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed plan
    for (int r = 0; r < NROWS; r++) begin
      if (PLAN[r].load) load_len(PLAN[r].len);
      pin_rd_on   = PLAN[r].pin_rd;
      pin_rd_val  = PLAN[r].rd;
      pin_ack_on  = PLAN[r].pin_ack;
      pin_ack_val = PLAN[r].ack;
      run_cmd(PLAN[r].cmd, PLAN[r].wr, PLAN[r].bits, PLAN[r].noise);
    end
    pin_rd_on  = 1'b0;
    pin_ack_on = 1'b0;

    // random traffic under three idling profiles
    load_len(pick_len());
    random_traffic(70);
    tx_gap_pct   = 45;
    rx_stall_pct = 18;
    load_len(pick_len());
    random_traffic(70);
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    load_len(pick_len());
    random_traffic(70);

    // drain, then give the output register time to show anything stray
    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- i2c_master_bit_sequencer_core.f -----
+incdir+design
design/i2cbs_pkg.sv
design/i2c_master_bit_sequencer_core.sv
design/i2cbs_checker.sv
sim/tb_i2c_master_bit_sequencer_core.sv
